// ----- rtl/core/lsa_pkg.sv -----
// Shared types and constants for the lateral steering accelerator.
// No dependencies; imported by lsa_arith and lateral_steering_accel.
`default_nettype none

package lsa_pkg;

   localparam int LSA_MAX_POINTS = 256;
   localparam int LSA_PROD_W     = 68;

   localparam logic [16:0] LSA_ONE         = 17'd65536;   // 1.0
   localparam logic [31:0] LSA_TENTH       = 32'd6554;    // 0.1
   localparam logic [31:0] LSA_DAMP_KNEE   = 32'd327680;  // 5.0
   localparam logic [33:0] LSA_FIFTH_RECIP = 34'd419431;  // 2^21 / 5, rounded up
   localparam logic [31:0] LSA_U32_MAX     = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      CSR_LOOKAHEAD_BASE    = 3'd0,
      CSR_LOOKAHEAD_GAIN    = 3'd1,
      CSR_PROP_GAIN         = 3'd2,
      CSR_DAMP_GAIN         = 3'd3,
      CSR_MIN_TURN_RADIUS   = 3'd4,
      CSR_MAX_LATERAL_ACCEL = 3'd5
   } lsa_csr_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_STEER = 1'b1
   } lsa_opcode_type;

   typedef enum logic [1:0] {
      AOP_MUL,
      AOP_DIV,
      AOP_SQRT
   } lsa_aop_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_NORM
   } lsa_state_type;

   typedef enum logic [4:0] {
      SP_VXX, SP_VYY, SP_SPEED, SP_LOOK,
      SP_TX0, SP_TX1, SP_TY0, SP_TY1,
      SP_UXX, SP_UYY, SP_NSQRT, SP_FX, SP_FY,
      SP_EL0, SP_EL1, SP_VL0, SP_VL1, SP_S0, SP_S1,
      SP_FV0, SP_FV1, SP_SAFE, SP_LIM, SP_DAMP, SP_SD,
      SP_AX, SP_AY
   } lsa_step_type;

   // request to the shared unit: mul uses a[33:0] x b (signed),
   // div uses a / b[31:0], sqrt uses a
   typedef struct packed {
      logic        go;
      lsa_aop_type op;
      logic [63:0] a;
      logic [33:0] b;
   } lsa_areq_type;

   typedef struct packed {
      logic                         done;
      logic signed [LSA_PROD_W-1:0] res;
   } lsa_arsp_type;

   typedef struct packed {
      lsa_opcode_type     operation;
      logic [7:0]         index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [16:0]        curve_param;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } lsa_req_type;

   typedef struct packed {
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
   } lsa_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/lsa_arith.sv -----
// Shared arithmetic unit: registered 34x34 multiply, radix-2 divide, bitwise sqrt.
// Depends on lsa_pkg.
`default_nettype none

module lsa_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  lsa_pkg::lsa_areq_type areq,
   output lsa_pkg::lsa_arsp_type arsp
);
   import lsa_pkg::*;

   logic                         run_ff;
   logic                         done_ff;
   logic [6:0]                   cnt_ff;
   lsa_aop_type                  op_ff;
   logic [63:0]                  src_ff;
   logic [63:0]                  quo_ff;
   logic [34:0]                  rem_ff;
   logic [31:0]                  dsr_ff;
   logic signed [LSA_PROD_W-1:0] prod_ff;

   logic [63:0]                  src_in;
   logic [63:0]                  quo_in;
   logic [34:0]                  rem_in;
   logic [34:0]                  shl;
   logic [34:0]                  trial;
   logic [35:0]                  diff;
   logic                         fit;
   logic signed [LSA_PROD_W-1:0] ma;
   logic signed [LSA_PROD_W-1:0] mb;

   assign ma = {{34{areq.a[33]}}, areq.a[33:0]};
   assign mb = {{34{areq.b[33]}}, areq.b};

   // one shared compare/subtract serves both divide and square root
   always_comb begin
      if (op_ff == AOP_SQRT) begin
         shl    = {rem_ff[32:0], src_ff[63:62]};
         trial  = {quo_ff[32:0], 2'b01};
         src_in = {src_ff[61:0], 2'b00};
      end else begin
         shl    = {rem_ff[33:0], src_ff[63]};
         trial  = {3'd0, dsr_ff};
         src_in = {src_ff[62:0], 1'b0};
      end
      diff   = {1'b0, shl} - {1'b0, trial};
      fit    = !diff[35];
      rem_in = fit ? diff[34:0] : shl;
      quo_in = {quo_ff[62:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (areq.go) begin
            op_ff  <= areq.op;
            src_ff <= areq.a;
            dsr_ff <= areq.b[31:0];
            rem_ff <= '0;
            quo_ff <= '0;
            if (areq.op == AOP_MUL) begin
               prod_ff <= ma * mb;
               done_ff <= 1'b1;
            end else begin
               run_ff <= 1'b1;
               cnt_ff <= (areq.op == AOP_SQRT) ? 7'd31 : 7'd63;
            end
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            src_ff <= src_in;
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign arsp.done = done_ff;
   assign arsp.res  = (op_ff == AOP_MUL) ? prod_ff : $signed({4'd0, quo_ff});

endmodule

`default_nettype wire

// ----- rtl/core/lateral_steering_accel.sv -----
// Top level of the PD lateral steering accelerator: path store, sequencer, registers.
// Depends on lsa_pkg and lsa_arith.
// A load gives no word; a short segment answers with a zero word in the next cycle.
// A steer issues its steps to the shared unit (22 multiplies, 2 square roots, 3 divides)
// and runs the normalising shifter before rsp_valid; a zero tangent ends it early with zero.
// One word at a time; busy is high meanwhile.
// Synchronous reset restores register defaults and empties the path (point count 0).
`default_nettype none

module lateral_steering_accel #(
   parameter int MAX_POINTS = lsa_pkg::LSA_MAX_POINTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lsa_pkg::lsa_req_type req_data,
   output logic                 rsp_valid,
   output lsa_pkg::lsa_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [30:0]          csr_wdata
);
   import lsa_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   // configuration
   logic [30:0] look_base_ff, look_gain_ff, prop_gain_ff, damp_gain_ff;
   logic [30:0] turn_rad_ff, max_acc_ff;

   // path store, undefined until loaded
   logic signed [31:0] path_xs [MAX_POINTS];
   logic signed [31:0] path_ys [MAX_POINTS];
   logic signed [31:0] rdx_ff, rdy_ff;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [8:0]         count_ff;

   // sequencer
   lsa_state_type state_ff, state_in;
   lsa_step_type  step_ff;
   logic          pend_ff;
   logic [1:0]    rdc_ff;
   lsa_req_type   in_ff;

   // datapath working registers
   logic signed [LSA_PROD_W-1:0] acc_ff;
   logic signed [31:0] p0x_ff, p1x_ff, p2x_ff, p0y_ff, p1y_ff, p2y_ff;
   logic [31:0]        speed_ff, n_ff, safe_ff;
   logic [16:0]        tl_ff, damp_ff;
   logic signed [50:0] tx_ff, ty_ff;
   logic [49:0]        ux_ff, uy_ff;
   logic signed [31:0] fx_ff, fy_ff, el_ff, vl_ff, ax_ff;
   logic signed [51:0] s_ff;
   logic               rsp_valid_ff;
   lsa_rsp_type        rsp_ff;

   lsa_areq_type ar_req;
   lsa_arsp_type ar_rsp;

   logic               accept, load_fit, seg_short, tzero;
   logic               norm_hi, norm_lo, norm_ok;
   logic [49:0]        norm_m;
   logic signed [50:0] ty_sum;
   logic signed [33:0] dx34, dy34, vx34, vy34;
   logic signed [LSA_PROD_W-1:0] pr;
   logic [49:0]        look_sum;
   logic signed [LSA_PROD_W-1:0] fv_full;
   logic [63:0]        quot;
   logic [30:0]        lim;
   logic [31:0]        rad;
   logic signed [LSA_PROD_W-1:0] neg_sh;

   function automatic logic signed [31:0] sat_sh30(input logic signed [LSA_PROD_W-1:0] v);
      logic signed [LSA_PROD_W-1:0] t;
      t = v >>> 30;
      if (t > $signed(68'sd2147483647)) return 32'sh7FFF_FFFF;
      if (t < -$signed(68'sd2147483648)) return 32'sh8000_0000;
      return t[31:0];
   endfunction

   function automatic logic [49:0] mag51(input logic signed [50:0] v);
      logic signed [50:0] n;
      n = -v;
      return v[50] ? n[49:0] : v[49:0];
   endfunction

   lsa_arith u_arith (
      .clock (clock),
      .reset (reset),
      .areq  (ar_req),
      .arsp  (ar_rsp)
   );

   assign accept    = start && !busy;
   assign load_fit  = 17'(req_data.index) < 17'(MAX_POINTS);
   assign seg_short = (10'(req_data.index) + 10'd2) >= {1'b0, count_ff};
   assign wr_addr   = AW'(req_data.index);
   assign rd_addr   = AW'({1'b0, in_ff.index} + {7'd0, rdc_ff});
   assign csr_ready = 1'b1;

   assign dx34 = 34'(in_ff.target_x) - 34'(in_ff.pos_x);
   assign dy34 = 34'(in_ff.target_y) - 34'(in_ff.pos_y);
   assign vx34 = 34'(in_ff.vel_x);
   assign vy34 = 34'(in_ff.vel_y);
   assign pr   = ar_rsp.res;

   assign ty_sum = ty_ff + pr[50:0];
   assign tzero  = (tx_ff == '0) && (ty_sum == '0);

   // normaliser: bring the larger tangent component into [2^30, 2^31)
   assign norm_m  = (ux_ff >= uy_ff) ? ux_ff : uy_ff;
   assign norm_hi = |norm_m[49:31];
   assign norm_lo = !norm_hi && !norm_m[30];
   assign norm_ok = !norm_hi && !norm_lo;

   assign look_sum = 50'(in_ff.curve_param) + 50'(look_base_ff) + 50'(pr[63:16]);
   assign fv_full  = (acc_ff + pr) >>> 30;
   assign quot     = pr[63:0];
   assign lim      = (quot < 64'(max_acc_ff)) ? quot[30:0] : max_acc_ff;
   assign rad      = (turn_rad_ff == '0) ? 32'd1 : {1'b0, turn_rad_ff};
   assign neg_sh   = (-pr) >>> 30;

   //--------------------------------------------------------------------------
   // configuration writes
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         look_base_ff <= 31'd0;
         look_gain_ff <= 31'd0;
         prop_gain_ff <= 31'd65536;
         damp_gain_ff <= 31'd65536;
         turn_rad_ff  <= 31'd327680;
         max_acc_ff   <= 31'd196608;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOOKAHEAD_BASE:    look_base_ff <= csr_wdata;
            CSR_LOOKAHEAD_GAIN:    look_gain_ff <= csr_wdata;
            CSR_PROP_GAIN:         prop_gain_ff <= csr_wdata;
            CSR_DAMP_GAIN:         damp_gain_ff <= csr_wdata;
            CSR_MIN_TURN_RADIUS:   turn_rad_ff  <= csr_wdata;
            CSR_MAX_LATERAL_ACCEL: max_acc_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   //--------------------------------------------------------------------------
   // path store: one write port (load), one registered read port (segment fetch)
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && req_data.operation == OP_LOAD && load_fit) begin
         path_xs[wr_addr] <= req_data.point_x;
         path_ys[wr_addr] <= req_data.point_y;
      end
      rdx_ff <= path_xs[rd_addr];
      rdy_ff <= path_ys[rd_addr];
   end

   //--------------------------------------------------------------------------
   // next state
   //--------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start && req_data.operation == OP_STEER && !seg_short) begin
            state_in = ST_READ;
         end
         ST_READ: if (rdc_ff == 2'd3) begin
            state_in = ST_CALC;
         end
         ST_CALC: if (ar_rsp.done) begin
            if (step_ff == SP_TY1) begin
               state_in = tzero ? ST_IDLE : ST_NORM;
            end else if (step_ff == SP_AY) begin
               state_in = ST_IDLE;
            end
         end
         ST_NORM: if (norm_ok) begin
            state_in = ST_CALC;
         end
      endcase
   end

   //--------------------------------------------------------------------------
   // outputs of the sequencer: issue to the shared unit, operands by step
   //--------------------------------------------------------------------------
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      ar_req    = '0;
      ar_req.go = (state_ff == ST_CALC) && !pend_ff;
      ar_req.op = AOP_MUL;
      unique case (step_ff)
         SP_VXX:   begin ar_req.a = 64'(vx34); ar_req.b = vx34; end
         SP_VYY:   begin ar_req.a = 64'(vy34); ar_req.b = vy34; end
         SP_SPEED: begin ar_req.op = AOP_SQRT; ar_req.a = acc_ff[63:0]; end
         SP_LOOK:  begin
            ar_req.a = {32'd0, speed_ff};
            ar_req.b = {3'd0, look_gain_ff};
         end
         SP_TX0:   begin
            ar_req.a = 64'(LSA_ONE - tl_ff);
            ar_req.b = 34'(p1x_ff) - 34'(p0x_ff);
         end
         SP_TX1:   begin
            ar_req.a = 64'(tl_ff);
            ar_req.b = 34'(p2x_ff) - 34'(p1x_ff);
         end
         SP_TY0:   begin
            ar_req.a = 64'(LSA_ONE - tl_ff);
            ar_req.b = 34'(p1y_ff) - 34'(p0y_ff);
         end
         SP_TY1:   begin
            ar_req.a = 64'(tl_ff);
            ar_req.b = 34'(p2y_ff) - 34'(p1y_ff);
         end
         SP_UXX:   begin ar_req.a = 64'(ux_ff[33:0]); ar_req.b = ux_ff[33:0]; end
         SP_UYY:   begin ar_req.a = 64'(uy_ff[33:0]); ar_req.b = uy_ff[33:0]; end
         SP_NSQRT: begin ar_req.op = AOP_SQRT; ar_req.a = acc_ff[63:0]; end
         SP_FX:    begin
            ar_req.op = AOP_DIV;
            ar_req.a  = 64'(ux_ff[30:0]) << 30;
            ar_req.b  = {2'd0, n_ff};
         end
         SP_FY:    begin
            ar_req.op = AOP_DIV;
            ar_req.a  = 64'(uy_ff[30:0]) << 30;
            ar_req.b  = {2'd0, n_ff};
         end
         SP_EL0:   begin ar_req.a = 64'(dx34); ar_req.b = 34'(fy_ff); end
         SP_EL1:   begin ar_req.a = 64'(dy34); ar_req.b = 34'(fx_ff); end
         SP_VL0:   begin ar_req.a = 64'(vx34); ar_req.b = 34'(fy_ff); end
         SP_VL1:   begin ar_req.a = 64'(vy34); ar_req.b = 34'(fx_ff); end
         SP_S0:    begin ar_req.a = {33'd0, prop_gain_ff}; ar_req.b = 34'(el_ff); end
         SP_S1:    begin ar_req.a = {33'd0, damp_gain_ff}; ar_req.b = 34'(vl_ff); end
         SP_FV0:   begin ar_req.a = 64'(vx34); ar_req.b = 34'(fx_ff); end
         SP_FV1:   begin ar_req.a = 64'(vy34); ar_req.b = 34'(fy_ff); end
         SP_SAFE:  begin ar_req.a = {32'd0, safe_ff}; ar_req.b = {2'd0, safe_ff}; end
         SP_LIM:   begin
            ar_req.op = AOP_DIV;
            ar_req.a  = acc_ff[63:0];
            ar_req.b  = {2'd0, rad};
         end
         SP_DAMP:  begin ar_req.a = {32'd0, speed_ff}; ar_req.b = LSA_FIFTH_RECIP; end
         SP_SD:    begin ar_req.a = 64'($signed(s_ff[32:0])); ar_req.b = {17'd0, damp_ff}; end
         SP_AX:    begin ar_req.a = 64'($signed(s_ff[32:0])); ar_req.b = 34'(fy_ff); end
         SP_AY:    begin ar_req.a = 64'($signed(s_ff[32:0])); ar_req.b = 34'(fx_ff); end
         default:  ;
      endcase
   end

   //--------------------------------------------------------------------------
   // control registers
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_VXX;
         pend_ff      <= 1'b0;
         rdc_ff       <= 2'd0;
         count_ff     <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (accept && req_data.operation == OP_LOAD && load_fit) begin
            count_ff <= 9'(req_data.index) + 9'd1;
         end
         if (accept && req_data.operation == OP_STEER) begin
            rdc_ff  <= 2'd0;
            step_ff <= SP_VXX;
            pend_ff <= 1'b0;
            if (seg_short) begin
               rsp_valid_ff <= 1'b1;   // segment beyond the path: zero word
            end
         end
         if (state_ff == ST_READ) begin
            rdc_ff <= rdc_ff + 2'd1;
         end
         if (ar_req.go) begin
            pend_ff <= 1'b1;
         end
         if (state_ff == ST_CALC && ar_rsp.done) begin
            pend_ff <= 1'b0;
            step_ff <= lsa_step_type'(step_ff + 5'd1);
            if ((step_ff == SP_TY1 && tzero) || step_ff == SP_AY) begin
               rsp_valid_ff <= 1'b1;
            end
         end
      end
   end

   //--------------------------------------------------------------------------
   // datapath registers
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
         if (req_data.operation == OP_STEER) begin
            rsp_ff <= '0;
         end
      end

      // three points arrive one per cycle behind the read address
      if (state_ff == ST_READ && rdc_ff != 2'd0) begin
         p0x_ff <= p1x_ff;  p1x_ff <= p2x_ff;  p2x_ff <= rdx_ff;
         p0y_ff <= p1y_ff;  p1y_ff <= p2y_ff;  p2y_ff <= rdy_ff;
      end

      if (state_ff == ST_NORM) begin
         if (norm_hi) begin
            ux_ff <= ux_ff >> 1;
            uy_ff <= uy_ff >> 1;
         end else if (norm_lo) begin
            ux_ff <= ux_ff << 1;
            uy_ff <= uy_ff << 1;
         end
      end

      if (state_ff == ST_CALC && ar_rsp.done) begin
         unique case (step_ff)
            SP_VXX, SP_UXX, SP_EL0, SP_VL0, SP_S0, SP_FV0, SP_SAFE: acc_ff <= pr;
            SP_VYY, SP_UYY: acc_ff <= acc_ff + pr;
            SP_SPEED: speed_ff <= pr[31:0];
            SP_LOOK:  tl_ff <= (look_sum > 50'(LSA_ONE)) ? LSA_ONE : look_sum[16:0];
            SP_TX0:   tx_ff <= pr[50:0];
            SP_TX1:   tx_ff <= tx_ff + pr[50:0];
            SP_TY0:   ty_ff <= pr[50:0];
            SP_TY1:   begin
               ty_ff <= ty_sum;
               ux_ff <= mag51(tx_ff);
               uy_ff <= mag51(ty_sum);
            end
            SP_NSQRT: n_ff <= pr[31:0];
            SP_FX:    fx_ff <= tx_ff[50] ? -$signed(pr[31:0]) : $signed(pr[31:0]);
            SP_FY:    fy_ff <= ty_ff[50] ? -$signed(pr[31:0]) : $signed(pr[31:0]);
            SP_EL1:   el_ff <= sat_sh30(pr - acc_ff);
            SP_VL1:   vl_ff <= sat_sh30(pr - acc_ff);
            SP_S1:    s_ff <= 52'((acc_ff - pr) >>> 16);
            SP_FV1:   begin
               if (fv_full < $signed({36'd0, LSA_TENTH})) begin
                  safe_ff <= LSA_TENTH;
               end else if (fv_full > $signed({36'd0, LSA_U32_MAX})) begin
                  safe_ff <= LSA_U32_MAX;
               end else begin
                  safe_ff <= fv_full[31:0];
               end
            end
            SP_LIM:   begin
               if (s_ff > $signed({21'd0, lim})) begin
                  s_ff <= $signed({21'd0, lim});
               end else if (s_ff < -$signed({21'd0, lim})) begin
                  s_ff <= -$signed({21'd0, lim});
               end
            end
            SP_DAMP:  damp_ff <= (speed_ff >= LSA_DAMP_KNEE) ? LSA_ONE : pr[37:21];
            SP_SD:    s_ff <= 52'(pr >>> 16);
            SP_AX:    ax_ff <= neg_sh[31:0];
            SP_AY:    begin
               rsp_ff.accel_x <= ax_ff;
               rsp_ff.accel_y <= $signed(pr[61:30]);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   //--------------------------------------------------------------------------
   // checks
   //--------------------------------------------------------------------------
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a word is still in work");

   a_done_answers_issue: assert property (@(posedge clock) disable iff (reset)
      ar_rsp.done |-> pend_ff)
      else $error("shared unit finished without an issued operation");

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM) |-> ((ux_ff | uy_ff) != '0))
      else $error("normalising a zero tangent");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_LOAD && load_fit)
         |=> (count_ff == $past(9'(req_data.index)) + 9'd1))
      else $error("point count not updated by load");

endmodule

`default_nettype wire

// ----- bench/lateral_steering_accel_test.sv -----
// Self-checking bench for lateral_steering_accel: directed and random loads and steers.
// A predictor computes each steer's acceleration from the path and register values.
// Depends on lsa_pkg and the lateral_steering_accel RTL.
`default_nettype none

module lateral_steering_accel_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lsa_pkg::*;

   typedef logic signed [127:0] wide_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   lsa_req_type req_data;
   logic        rsp_valid;
   lsa_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [30:0] csr_wdata;

   lateral_steering_accel DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor's copy of the block state
   longint          pt_x [LSA_MAX_POINTS];
   longint          pt_y [LSA_MAX_POINTS];
   bit              pt_known [LSA_MAX_POINTS];
   int              pt_count;
   longint unsigned reg_val [6];

   lsa_rsp_type expected_accel [$];
   int          failures;
   int          stall_cycles;
   int          send_gap_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic wide_t sat32(wide_t x);
      if (x > wide_t'(32'sh7FFF_FFFF)) return wide_t'(32'sh7FFF_FFFF);
      if (x < -wide_t'(64'sh8000_0000)) return -wide_t'(64'sh8000_0000);
      return x;
   endfunction

   // steering acceleration for one steer word, from current path and registers
   function automatic lsa_rsp_type steer_accel(lsa_req_type rq);
      lsa_rsp_type     acc;
      int              i0;
      longint          vx, vy, tx, ty, fx, fy, dx, dy;
      longint unsigned speed, tl, mx, my, mg, nrm, rad, dampf;
      wide_t           el, vl, s, fv, safe, q, lim;
      acc = '0;
      i0  = rq.index;
      if (i0 + 2 >= pt_count) return acc;
      vx    = rq.vel_x;
      vy    = rq.vel_y;
      speed = int_sqrt(longint'(vx * vx) + longint'(vy * vy));
      tl    = rq.curve_param + reg_val[CSR_LOOKAHEAD_BASE]
              + ((speed * reg_val[CSR_LOOKAHEAD_GAIN]) >> 16);
      if (tl > 65536) tl = 65536;
      tx = longint'(65536 - tl) * (pt_x[i0+1] - pt_x[i0])
           + longint'(tl) * (pt_x[i0+2] - pt_x[i0+1]);
      ty = longint'(65536 - tl) * (pt_y[i0+1] - pt_y[i0])
           + longint'(tl) * (pt_y[i0+2] - pt_y[i0+1]);
      if (tx == 0 && ty == 0) return acc;
      // normalise the tangent so its larger component sits in [2^30, 2^31)
      mx = (tx < 0) ? -tx : tx;
      my = (ty < 0) ? -ty : ty;
      mg = (mx > my) ? mx : my;
      while (mg >= (64'd1 << 31)) begin mx >>= 1; my >>= 1; mg >>= 1; end
      while (mg <  (64'd1 << 30)) begin mx <<= 1; my <<= 1; mg <<= 1; end
      nrm = int_sqrt(mx * mx + my * my);
      fx  = (mx << 30) / nrm;
      fy  = (my << 30) / nrm;
      if (tx < 0) fx = -fx;
      if (ty < 0) fy = -fy;
      dx = longint'(rq.target_x) - longint'(rq.pos_x);
      dy = longint'(rq.target_y) - longint'(rq.pos_y);
      el = sat32((-wide_t'(dx) * fy + wide_t'(dy) * fx) >>> 30);
      vl = sat32((-wide_t'(vx) * fy + wide_t'(vy) * fx) >>> 30);
      s  = (wide_t'(reg_val[CSR_PROP_GAIN]) * el
            - wide_t'(reg_val[CSR_DAMP_GAIN]) * vl) >>> 16;
      // curvature limit from forward speed, floored at a tenth
      fv = (wide_t'(vx) * fx + wide_t'(vy) * fy) >>> 30;
      if (fv < wide_t'(LSA_TENTH)) fv = wide_t'(LSA_TENTH);
      safe = (fv > wide_t'(LSA_U32_MAX)) ? wide_t'(LSA_U32_MAX) : fv;
      rad  = (reg_val[CSR_MIN_TURN_RADIUS] == 0) ? 1 : reg_val[CSR_MIN_TURN_RADIUS];
      q    = (safe * safe) / wide_t'(rad);
      lim  = (wide_t'(reg_val[CSR_MAX_LATERAL_ACCEL]) < q)
             ? wide_t'(reg_val[CSR_MAX_LATERAL_ACCEL]) : q;
      if (s > lim)  s = lim;
      if (s < -lim) s = -lim;
      // slow-speed fade
      dampf = speed / 5;
      if (dampf > 65536) dampf = 65536;
      s = (s * wide_t'(dampf)) >>> 16;
      acc.accel_x = 32'((s * -wide_t'(fy)) >>> 30);
      acc.accel_y = 32'((s * wide_t'(fx)) >>> 30);
      return acc;
   endfunction

   // track one accepted word in the predictor
   function automatic void predict_word(lsa_req_type rq);
      if (rq.operation == OP_LOAD) begin
         pt_x[rq.index]     = longint'(rq.point_x);
         pt_y[rq.index]     = longint'(rq.point_y);
         pt_known[rq.index] = 1'b1;
         pt_count           = int'(rq.index) + 1;
      end else begin
         expected_accel.push_back(steer_accel(rq));
      end
   endfunction

   // a steer is legal unless it would read a point never loaded
   function automatic bit steer_legal(int idx);
      if (idx + 2 >= pt_count) return 1'b1;
      return pt_known[idx] && pt_known[idx+1] && pt_known[idx+2];
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
         default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_vel();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h0005_0000)) - 32'h0002_8000;
         default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      endcase
   endfunction

   function automatic lsa_req_type load_word(int idx, logic [31:0] x, logic [31:0] y);
      lsa_req_type rq;
      rq           = '0;
      rq.operation = OP_LOAD;
      rq.index     = idx;
      rq.point_x   = x;
      rq.point_y   = y;
      // steer-only fields carry noise; the block should ignore them
      rq.curve_param = $urandom;
      rq.pos_x       = $urandom;
      rq.vel_y       = $urandom;
      return rq;
   endfunction

   function automatic lsa_req_type steer_word(int idx);
      lsa_req_type rq;
      rq             = '0;
      rq.operation   = OP_STEER;
      rq.index       = idx;
      rq.point_x     = $urandom;
      rq.point_y     = $urandom;
      rq.curve_param = $urandom_range(0, 7) == 0 ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, 65536);
      rq.pos_x       = rand_coord();
      rq.pos_y       = rand_coord();
      rq.vel_x       = rand_vel();
      rq.vel_y       = rand_vel();
      rq.target_x    = rand_coord();
      rq.target_y    = rand_coord();
      return rq;
   endfunction

   // send one word; start is left high, the caller lowers it when going idle
   task automatic send_word(lsa_req_type rq);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      predict_word(rq);
   endtask

   // let the block drain; a trailing load gives no word, so also wait for busy low
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (expected_accel.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(lsa_csr_type r, logic [30:0] v);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      reg_val[r]  = v;
   endtask

   task automatic load_path(int base, int len);
      for (int i = 0; i < len; i++)
         send_word(load_word(base + i, rand_coord(), rand_coord()));
   endtask

   // edges of the fields and each special case
   task automatic test_directed;
      lsa_req_type rq;
      rq = steer_word(0);
      send_word(rq);                                    // empty path: zero
      send_word(load_word(0, 32'h0, 32'h0));
      send_word(load_word(1, 32'h0001_0000, 32'h0));
      send_word(load_word(2, 32'h0002_0000, 32'h0001_0000));
      rq = steer_word(0); rq.curve_param = 0;      rq.vel_x = 0; rq.vel_y = 0;
      send_word(rq);                                    // standing still
      rq = steer_word(0); rq.curve_param = 65536;  rq.vel_x = 32'h0010_0000;
      send_word(rq);
      rq = steer_word(0); rq.curve_param = 131071; // parameter above one
      send_word(rq);
      rq = steer_word(0); rq.vel_x = 32'h8000_0000; rq.vel_y = 32'h8000_0000;
      rq.target_x = 32'h7FFF_FFFF; rq.pos_x = 32'h8000_0000;
      rq.target_y = 32'h8000_0000; rq.pos_y = 32'h7FFF_FFFF;
      send_word(rq);                                    // everything at its extreme
      rq = steer_word(0); rq.vel_x = 32'h7FFF_FFFF; rq.vel_y = 32'h7FFF_FFFF;
      send_word(rq);
      rq = steer_word(1);                               // segment past the path
      send_word(rq);
      // zero tangent: three coincident points
      send_word(load_word(3, 32'h0005_0000, 32'hFFFB_0000));
      send_word(load_word(4, 32'h0005_0000, 32'hFFFB_0000));
      send_word(load_word(5, 32'h0005_0000, 32'hFFFB_0000));
      send_word(steer_word(3));
      // extremes of the points
      send_word(load_word(6, 32'h7FFF_FFFF, 32'h8000_0000));
      send_word(load_word(7, 32'h8000_0000, 32'h7FFF_FFFF));
      send_word(steer_word(5));
      // top of the store
      send_word(load_word(253, 32'h0001_0000, 32'h0001_0000));
      send_word(load_word(254, 32'h0003_0000, 32'h0002_0000));
      send_word(load_word(255, 32'h0004_0000, 32'h0005_0000));
      send_word(steer_word(253));
      send_word(steer_word(255));
      send_word(steer_word(254));
      drain();
   endtask

   // well-formed path-and-steer runs with noise mixed in
   task automatic test_random(int n_items, bit hold_off);
      int sent, base, len, idx;
      sent = 0;
      while (sent < n_items) begin
         if (hold_off && sent >= n_items / 2) begin
            // sender holds back until every expected word has come
            start <= 1'b0;
            do @(posedge clock); while (expected_accel.size() != 0);
            hold_off = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               len  = $urandom_range(3, 7);
               base = $urandom_range(0, 10) == 0 ? LSA_MAX_POINTS - len
                                                 : $urandom_range(0, 40);
               load_path(base, len);
               sent += len;
               repeat ($urandom_range(1, 4)) begin
                  send_word(steer_word($urandom_range(base, base + len - 3)));
                  sent++;
               end
            end
            6, 7: begin
               send_word(load_word($urandom_range(0, 255), rand_coord(), rand_coord()));
               sent++;
            end
            default: begin
               idx = $urandom_range(0, 255);
               if (!steer_legal(idx)) idx = pt_count;
               if (idx <= 255) begin
                  send_word(steer_word(idx));
                  sent++;
               end
            end
         endcase
      end
      drain();
   endtask

   // register sweep, extremes included, each followed by random traffic
   task automatic test_settings;
      write_reg(CSR_LOOKAHEAD_BASE, 31'h7FFF_FFFF);
      write_reg(CSR_LOOKAHEAD_GAIN, 31'h7FFF_FFFF);
      write_reg(CSR_PROP_GAIN, 31'h7FFF_FFFF);
      write_reg(CSR_DAMP_GAIN, 31'h7FFF_FFFF);
      write_reg(CSR_MIN_TURN_RADIUS, 31'h0);           // treated as one LSB
      write_reg(CSR_MAX_LATERAL_ACCEL, 31'h7FFF_FFFF);
      test_random(120, 1'b0);
      write_reg(CSR_LOOKAHEAD_BASE, 31'h0);
      write_reg(CSR_LOOKAHEAD_GAIN, 31'h0);
      write_reg(CSR_PROP_GAIN, 31'h0);
      write_reg(CSR_DAMP_GAIN, 31'h0);
      write_reg(CSR_MIN_TURN_RADIUS, 31'h7FFF_FFFF);
      write_reg(CSR_MAX_LATERAL_ACCEL, 31'h0);
      test_random(100, 1'b0);
      write_reg(CSR_LOOKAHEAD_BASE, $urandom_range(0, 32'h4000));
      write_reg(CSR_LOOKAHEAD_GAIN, $urandom_range(0, 32'h2000));
      write_reg(CSR_PROP_GAIN, $urandom_range(0, 32'h0004_0000));
      write_reg(CSR_DAMP_GAIN, $urandom_range(0, 32'h0004_0000));
      write_reg(CSR_MIN_TURN_RADIUS, 31'h1);
      write_reg(CSR_MAX_LATERAL_ACCEL, $urandom_range(0, 32'h0010_0000));
      test_random(150, 1'b0);
      write_reg(CSR_MIN_TURN_RADIUS, 31'd327680);
      write_reg(CSR_MAX_LATERAL_ACCEL, 31'd196608);
   endtask

   // every result word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_accel.size() == 0) begin
            $error("unexpected word: accel_x %0d accel_y %0d",
                   rsp_data.accel_x, rsp_data.accel_y);
            failures++;
         end else begin
            if (rsp_data.accel_x !== expected_accel[0].accel_x) begin
               $error("accel_x expected %0d actual %0d",
                      expected_accel[0].accel_x, rsp_data.accel_x);
               failures++;
            end
            if (rsp_data.accel_y !== expected_accel[0].accel_y) begin
               $error("accel_y expected %0d actual %0d",
                      expected_accel[0].accel_y, rsp_data.accel_y);
               failures++;
            end
            void'(expected_accel.pop_front());
         end
      end
   end

   // watchdog on cycles without an accepted word, a result or a register write
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 20000) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      failures     = 0;
      stall_cycles = 0;
      send_gap_pct = 10;
      pt_count     = 0;
      foreach (pt_known[i]) begin
         pt_known[i] = 1'b0;
         pt_x[i]     = 0;
         pt_y[i]     = 0;
      end
      reg_val[CSR_LOOKAHEAD_BASE]    = 0;
      reg_val[CSR_LOOKAHEAD_GAIN]    = 0;
      reg_val[CSR_PROP_GAIN]         = 65536;
      reg_val[CSR_DAMP_GAIN]         = 65536;
      reg_val[CSR_MIN_TURN_RADIUS]   = 327680;
      reg_val[CSR_MAX_LATERAL_ACCEL] = 196608;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_settings();
      test_random(250, 1'b1);
      send_gap_pct = 65;
      write_reg(CSR_LOOKAHEAD_GAIN, 31'h0000_0800);
      test_random(200, 1'b0);
      send_gap_pct = 0;
      write_reg(CSR_LOOKAHEAD_BASE, 31'h0000_1000);
      test_random(200, 1'b0);

      drain();
      repeat (400) @(posedge clock);
      if (failures == 0 && expected_accel.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
